[design/wsled_pkg.sv]
package wsled_pkg;

  // Number of interfaces tracked in the masks
  localparam int VIF_COUNT = 8;
  localparam int VIF_IDX_W = 4;

  // Reset values of the configuration registers
  localparam logic       LEDS_ENABLED_RST = 1'b1;
  localparam logic       ACTIVE_HIGH_RST  = 1'b1;
  localparam logic [7:0] TOGGLE_TICKS_RST = 8'd2;
  localparam logic [7:0] IDLE_LIMIT_RST   = 8'd10;

  typedef logic [VIF_COUNT-1:0] vif_mask_t;

  typedef enum logic [1:0] {
    OP_CONN = 2'd0,
    OP_SCAN = 2'd1,
    OP_ACT  = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_LEDS_ENABLED = 2'd0,
    REG_ACTIVE_HIGH  = 2'd1,
    REG_TOGGLE_TICKS = 2'd2,
    REG_IDLE_LIMIT   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t                  opcode;
    logic [VIF_IDX_W-1:0] vif_index;
    logic                 now_active;
  } in_item_t;

  typedef struct packed {
    logic activity_pin;
    logic scanning_pin;
  } out_item_t;

  typedef struct packed {
    logic       leds_enabled;
    logic       active_high;
    logic [7:0] toggle_period_ticks;
    logic [7:0] idle_period_limit;
  } led_cfg_t;

endpackage

[design/wlan_status_led_controller.sv]
// The input transfer loads the input register, and the item moves on into the result register
// at the next edge unless a full, untaken result holds it there.
// Throughput: one item per cycle unless the result stalls, set by the single-pass update.
// The input side stalls only while the result register is full and not taken.
// Reset (synchronous, rst_n low): pipeline empties, registers return to defaults,
// masks clear, timer armed with two ticks, both LEDs at their unlit level.
module wlan_status_led_controller import wsled_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  reg_idx_t  cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  led_cfg_t  cfg_r;
  logic      advance;
  out_item_t result_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leds_enabled        <= LEDS_ENABLED_RST;
      cfg_r.active_high         <= ACTIVE_HIGH_RST;
      cfg_r.toggle_period_ticks <= TOGGLE_TICKS_RST;
      cfg_r.idle_period_limit   <= IDLE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEDS_ENABLED: cfg_r.leds_enabled        <= cfg_wdata[0];
        REG_ACTIVE_HIGH:  cfg_r.active_high         <= cfg_wdata[0];
        REG_TOGGLE_TICKS: cfg_r.toggle_period_ticks <= cfg_wdata;
        REG_IDLE_LIMIT:   cfg_r.idle_period_limit   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register: take a transfer whenever the stage is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result_nxt;
    end
  end

  wsled_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step       (advance),
    .item       (s1_item_r),
    .result_nxt (result_nxt)
  );

endmodule

[design/wsled_core.sv]
module wsled_core import wsled_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  led_cfg_t  cfg,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result_nxt
);

  vif_mask_t  conn_mask_r, conn_mask_nxt;
  vif_mask_t  scan_mask_r, scan_mask_nxt;
  logic       seen_r, seen_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic       armed_r, armed_nxt;
  logic [7:0] ticks_r, ticks_nxt;
  logic       act_lvl_r, act_lvl_nxt;
  logic       scan_lvl_r, scan_lvl_nxt;

  logic       vif_ok;
  vif_mask_t  vif_bit;
  logic       conn_any;

  assign vif_ok   = {1'b0, item.vif_index} < (VIF_IDX_W+1)'(VIF_COUNT);
  assign vif_bit  = vif_mask_t'(1) << item.vif_index;
  assign conn_any = |conn_mask_r;

  // Work out the state after one item
  always_comb begin
    conn_mask_nxt = conn_mask_r;
    scan_mask_nxt = scan_mask_r;
    seen_nxt      = seen_r;
    idle_nxt      = idle_r;
    armed_nxt     = armed_r;
    ticks_nxt     = ticks_r;
    act_lvl_nxt   = act_lvl_r;
    scan_lvl_nxt  = scan_lvl_r;
    if (cfg.leds_enabled) begin
      case (item.opcode)
        OP_CONN: begin
          if (vif_ok) begin
            conn_mask_nxt = item.now_active ? (conn_mask_r | vif_bit)
                                            : (conn_mask_r & ~vif_bit);
            // light or darken only when emptiness flips
            if ((|conn_mask_nxt) != conn_any) begin
              act_lvl_nxt = (|conn_mask_nxt) ? cfg.active_high : ~cfg.active_high;
            end
          end
        end
        OP_SCAN: begin
          if (vif_ok) begin
            scan_mask_nxt = item.now_active ? (scan_mask_r | vif_bit)
                                            : (scan_mask_r & ~vif_bit);
            if (conn_any) begin
              scan_lvl_nxt = ~cfg.active_high;
            end else if ((|scan_mask_nxt) != (|scan_mask_r)) begin
              scan_lvl_nxt = (|scan_mask_nxt) ? cfg.active_high : ~cfg.active_high;
            end
          end
        end
        OP_ACT: begin
          if (conn_any) begin
            seen_nxt = 1'b1;
            if (!armed_r) begin
              armed_nxt = 1'b1;
              ticks_nxt = cfg.toggle_period_ticks;
            end
          end
        end
        OP_TICK: begin
          if (armed_r) begin
            if (ticks_r <= 8'd1) begin
              // timer expiry
              if (seen_r) begin
                act_lvl_nxt = ~act_lvl_r;
                armed_nxt   = 1'b1;
                ticks_nxt   = cfg.toggle_period_ticks;
                idle_nxt    = '0;
                seen_nxt    = 1'b0;
              end else if (idle_r < cfg.idle_period_limit) begin
                idle_nxt  = idle_r + 8'd1;
                armed_nxt = 1'b1;
                ticks_nxt = cfg.toggle_period_ticks;
              end else begin
                act_lvl_nxt = conn_any ? cfg.active_high : ~cfg.active_high;
                idle_nxt    = '0;
                armed_nxt   = 1'b0;
                ticks_nxt   = '0;
              end
            end else begin
              ticks_nxt = ticks_r - 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_nxt.activity_pin = act_lvl_nxt;
  assign result_nxt.scanning_pin = scan_lvl_nxt;

  // Hold state; advance on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_mask_r <= '0;
      scan_mask_r <= '0;
      seen_r      <= 1'b0;
      idle_r      <= '0;
      armed_r     <= 1'b1;
      ticks_r     <= TOGGLE_TICKS_RST;
      act_lvl_r   <= ~ACTIVE_HIGH_RST;
      scan_lvl_r  <= ~ACTIVE_HIGH_RST;
    end else if (step) begin
      conn_mask_r <= conn_mask_nxt;
      scan_mask_r <= scan_mask_nxt;
      seen_r      <= seen_nxt;
      idle_r      <= idle_nxt;
      armed_r     <= armed_nxt;
      ticks_r     <= ticks_nxt;
      act_lvl_r   <= act_lvl_nxt;
      scan_lvl_r  <= scan_lvl_nxt;
    end
  end

endmodule

[design/wsled_checker.sv]
module wsled_port_checker import wsled_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input stalls only behind a full, untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // An accepted item moves on into a free result register at the next edge
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted item did not produce a result");

endmodule

bind wlan_status_led_controller wsled_port_checker u_wsled_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
